// File: rtl/s2dh_pkg.sv
`default_nettype none
package s2dh_pkg;

    localparam int GRID_COLS       = 64;
    localparam int GRID_ROWS       = 64;
    localparam int X_ORIGIN_OFFSET = 32;
    localparam int Y_ORIGIN_OFFSET = 32;

    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int IDX_W      = $clog2(CELL_COUNT);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef logic [2:0] t_op;

    localparam t_op OP_NOP   = 3'd0;
    localparam t_op OP_ADD   = 3'd1;
    localparam t_op OP_FAIL  = 3'd2;
    localparam t_op OP_QUERY = 3'd3;
    localparam t_op OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [31:0] add_amount;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [31:0]        cell_value;
        logic signed [15:0] box_low_x;
        logic signed [15:0] box_high_x;
        logic signed [15:0] box_low_y;
        logic signed [15:0] box_high_y;
    } t_out_word;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [31:0]        amount;
    } t_q_word;

endpackage
`default_nettype wire

// File: rtl/signed_2d_histogram_accumulator_top.sv
// Path: an add or query word goes through a queue slot, the registered counter read and then
// the registered result; other operations through a queue slot and the registered result.
// The back end takes no new word until an add or query has had its registered counter read
// and then its write-back or result; clear then zeros the store with a sweep.
// Reset: synchronous active low; afterwards the store is swept to zero with o_in_ready low.
`default_nettype none
module signed_2d_histogram_accumulator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire s2dh_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output s2dh_pkg::t_out_word     o_out_data
);
    import s2dh_pkg::*;

    logic    push;
    t_q_word push_data;
    logic    q_full;
    logic    q_valid;
    t_q_word q_data;
    logic    q_pop;
    logic    init_busy;

    s2dh_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_push_data (push_data)
    );

    s2dh_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    s2dh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: rtl/s2dh_front.sv
`default_nettype none
module s2dh_front (
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire s2dh_pkg::t_in_word i_in_data,
    input  wire logic             i_q_full,
    input  wire logic             i_init_busy,
    output logic                  o_push,
    output s2dh_pkg::t_q_word     o_push_data
);
    import s2dh_pkg::*;

    logic signed [16:0] col;
    logic signed [16:0] row;
    logic               in_grid;
    logic               amt_pos;
    t_op                op;

    always_comb begin
        col     = 17'(i_in_data.coord_x) + 17'(X_ORIGIN_OFFSET);
        row     = 17'(i_in_data.coord_y) + 17'(Y_ORIGIN_OFFSET);
        in_grid = !col[16] && (col < 17'(GRID_COLS))
               && !row[16] && (row < 17'(GRID_ROWS));
        amt_pos = !i_in_data.add_amount[31] && (i_in_data.add_amount != 32'sd0);

        unique case (i_in_data.func)
            FUNC_ADD:   op = amt_pos ? (in_grid ? OP_ADD : OP_FAIL) : OP_NOP;
            FUNC_QUERY: op = in_grid ? OP_QUERY : OP_NOP;
            FUNC_CLEAR: op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
    end

    assign o_in_ready = !i_q_full && !i_init_busy;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_push_data.op      = op;
        o_push_data.idx     = IDX_W'(col) * IDX_W'(GRID_ROWS) + IDX_W'(row);
        o_push_data.coord_x = i_in_data.coord_x;
        o_push_data.coord_y = i_in_data.coord_y;
        o_push_data.amount  = i_in_data.add_amount;
    end

endmodule
`default_nettype wire

// File: rtl/s2dh_queue.sv
`default_nettype none
module s2dh_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire s2dh_pkg::t_q_word i_push_data,
    output logic                   o_full,
    output logic                   o_valid,
    output s2dh_pkg::t_q_word      o_data,
    input  wire logic              i_pop
);
    import s2dh_pkg::*;

    t_q_word         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/s2dh_back.sv
`default_nettype none
module s2dh_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire s2dh_pkg::t_q_word i_q_data,
    output logic                   o_q_pop,
    output logic                   o_init_busy,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output s2dh_pkg::t_out_word    o_out_data
);
    import s2dh_pkg::*;

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [31:0]        mem [CELL_COUNT];
    logic [31:0]        r_rd;

    logic [1:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_sweep_cnt, n_sweep_cnt;
    logic               r_init, n_init;
    logic signed [15:0] r_low_x, n_low_x;
    logic signed [15:0] r_high_x, n_high_x;
    logic signed [15:0] r_low_y, n_low_y;
    logic signed [15:0] r_high_y, n_high_y;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;
    t_q_word            r_cur, n_cur;

    logic               slot_free;
    logic               produce;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_waddr;
    logic [31:0]        mem_wdata;
    logic [32:0]        sum;
    logic [31:0]        sat;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_init_busy = r_init;

    always_comb begin
        sum = {1'b0, r_rd} + {1'b0, r_cur.amount};
        sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    always_comb begin
        n_state     = r_state;
        n_sweep_cnt = r_sweep_cnt;
        n_init      = r_init;
        n_low_x     = r_low_x;
        n_high_x    = r_high_x;
        n_low_y     = r_low_y;
        n_high_y    = r_high_y;
        n_cur       = r_cur;
        o_q_pop     = 1'b0;
        produce     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_sweep_cnt;
        mem_wdata   = '0;
        n_out       = r_out;
        n_out.ok         = 1'b1;
        n_out.cell_value = '0;

        unique case (r_state)
            S_SWEEP: begin
                mem_we      = 1'b1;
                n_sweep_cnt = r_sweep_cnt + 1'b1;
                if (r_sweep_cnt == IDX_W'(CELL_COUNT-1)) begin
                    n_sweep_cnt = '0;
                    n_init      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_data;
                    unique case (i_q_data.op) inside
                        OP_ADD, OP_QUERY: begin
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                        OP_CLEAR: begin
                            // box back to origin now; store zeroed by sweep
                            n_low_x  = '0;
                            n_high_x = '0;
                            n_low_y  = '0;
                            n_high_y = '0;
                            produce  = 1'b1;
                            n_state  = S_SWEEP;
                        end
                        OP_FAIL: begin
                            n_out.ok = 1'b0;
                            produce  = 1'b1;
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    produce = 1'b1;
                    n_state = S_IDLE;
                    if (r_cur.op == OP_ADD) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cur.idx;
                        mem_wdata = sat;
                        if (r_cur.coord_x < r_low_x)  n_low_x  = r_cur.coord_x;
                        if (r_cur.coord_x > r_high_x) n_high_x = r_cur.coord_x;
                        if (r_cur.coord_y < r_low_y)  n_low_y  = r_cur.coord_y;
                        if (r_cur.coord_y > r_high_y) n_high_y = r_cur.coord_y;
                    end else begin
                        n_out.cell_value = r_rd;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.box_low_x  = n_low_x;
        n_out.box_high_x = n_high_x;
        n_out.box_low_y  = n_low_y;
        n_out.box_high_y = n_high_y;

        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_cnt <= '0;
            r_init      <= 1'b1;
            r_low_x     <= '0;
            r_high_x    <= '0;
            r_low_y     <= '0;
            r_high_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_cnt <= n_sweep_cnt;
            r_init      <= n_init;
            r_low_x     <= n_low_x;
            r_high_x    <= n_high_x;
            r_low_y     <= n_low_y;
            r_high_y    <= n_high_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (produce) begin
            r_out <= n_out;
        end
    end

    // counter store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[i_q_data.idx];
        end
    end

endmodule
`default_nettype wire

// File: rtl/s2dh_checker.sv
`default_nettype none
module s2dh_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire s2dh_pkg::t_in_word i_in_data,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire s2dh_pkg::t_out_word o_out_data
);
    import s2dh_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word dropped or changed while stalled");

    // a failed add never carries a count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> o_out_data.cell_value == 32'd0)
        else $error("failed word with non-zero value");

    // box always contains the origin
    a_box_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.box_low_x <= 16'sd0 && o_out_data.box_high_x >= 16'sd0
                     && o_out_data.box_low_y <= 16'sd0 && o_out_data.box_high_y >= 16'sd0)
        else $error("bounding box excludes origin");

    // store sweep after reset holds off input
    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("input taken during reset sweep");

endmodule

bind signed_2d_histogram_accumulator_top s2dh_checker u_s2dh_checker (.*);
`default_nettype wire
